// ===== design/hpp_pkg.sv =====
// Shared types and constants for the homogeneous point projector.
// No dependencies; imported by the register file and the top level.
package hpp_pkg;

	localparam int NUM_REGS  = 6;
	localparam int ADDR_BITS = 6;
	localparam int WORD_BITS = 64;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [2:0] REG_ROW3_COLS01 = 3'd4;
	localparam logic [2:0] REG_ROW3_COLS23 = 3'd5;

	localparam logic [WORD_BITS-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
	localparam logic [WORD_BITS-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
	localparam logic [WORD_BITS-1:0] RST_ROW3_COLS23 = 64'h0001_0000_0000_0000;
	localparam logic [WORD_BITS-1:0] RST_ZERO        = 64'h0;

	typedef logic [WORD_BITS-1:0] reg_word_t;

	// Matrix rows 0, 1 and 3, two coefficients per word
	typedef struct packed {
		reg_word_t r0c01;
		reg_word_t r0c23;
		reg_word_t r1c01;
		reg_word_t r1c23;
		reg_word_t r3c01;
		reg_word_t r3c23;
	} hpp_matrix_t;

endpackage

// ===== design/homogeneous_point_projector.sv =====
// Top level of the homogeneous point projector: row dot products, divide, saturate.
// Depends on hpp_pkg, hpp_regs, hpp_dot and hpp_div.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  point    | point_valid, point_ready  | point_x, point_y, point_z
//  screen   | screen_valid, screen_ready| screen_x, screen_y, visible
//  config   | psel, penable, pready     | paddr, pwrite, pwdata, prdata
//
// One point enters per cycle while point_ready is high. A result passes through
// the product and sum stages, the magnitude stage, the one-bit-per-stage divider
// (DATA_WIDTH+2 stages) and the saturating output register. The whole pipeline
// advances together; while a result waits at the output, every stage holds and
// point_ready is low. Reset clears the valid bits and loads the default matrix.
module homogeneous_point_projector import hpp_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_ready,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	output logic                 screen_valid,
	input  logic                 screen_ready,
	output logic signed [31:0]   screen_x,
	output logic signed [31:0]   screen_y,
	output logic                 visible,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  reg_word_t            pwdata,
	output reg_word_t            prdata,
	output logic                 pready
);

	localparam int DW  = DATA_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int SW  = 2*DW-FB+2;
	localparam int NW  = SW+FB;
	localparam int QB  = DW+1;
	localparam int LAT = QB+1;

	hpp_matrix_t mat;
	logic        adv;

	logic signed [DW-1:0] px, py, pz;
	logic signed [SW-1:0] nx, ny, w;

	logic            v_s1, v_s2, v_s3;
	logic [SW-1:0]   nx_mag_s3, ny_mag_s3, w_mag_s3;
	logic            negx_s3, negy_s3, wzero_s3, wpos_s3;

	logic            v_d     [0:LAT-1];
	logic            negx_d  [0:LAT-1];
	logic            negy_d  [0:LAT-1];
	logic            wzero_d [0:LAT-1];
	logic            wpos_d  [0:LAT-1];

	logic [QB-1:0]   qx, qy;
	logic            ovfx, ovfy;
	logic [DW-1:0]   resx, resy;

	logic                  out_valid_q;
	logic signed [31:0]    sx_q, sy_q;
	logic                  vis_q;

	assign adv          = ~out_valid_q | screen_ready;
	assign point_ready  = adv;
	assign screen_valid = out_valid_q;
	assign screen_x     = sx_q;
	assign screen_y     = sy_q;
	assign visible      = vis_q;

	assign px = point_x[DW-1:0];
	assign py = point_y[DW-1:0];
	assign pz = point_z[DW-1:0];

	hpp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.matrix (mat)
	);

	hpp_dot #(.DW(DW), .FB(FB), .SW(SW)) u_dot0 (
		.clk(clk), .en(adv),
		.c0(mat.r0c01[DW-1:0]), .c1(mat.r0c01[32+DW-1:32]),
		.c2(mat.r0c23[DW-1:0]), .c3(mat.r0c23[32+DW-1:32]),
		.px(px), .py(py), .pz(pz), .sum(nx)
	);

	hpp_dot #(.DW(DW), .FB(FB), .SW(SW)) u_dot1 (
		.clk(clk), .en(adv),
		.c0(mat.r1c01[DW-1:0]), .c1(mat.r1c01[32+DW-1:32]),
		.c2(mat.r1c23[DW-1:0]), .c3(mat.r1c23[32+DW-1:32]),
		.px(px), .py(py), .pz(pz), .sum(ny)
	);

	hpp_dot #(.DW(DW), .FB(FB), .SW(SW)) u_dot3 (
		.clk(clk), .en(adv),
		.c0(mat.r3c01[DW-1:0]), .c1(mat.r3c01[32+DW-1:32]),
		.c2(mat.r3c23[DW-1:0]), .c3(mat.r3c23[32+DW-1:32]),
		.px(px), .py(py), .pz(pz), .sum(w)
	);

	// Advance the valid bits through the dot product stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Take magnitudes and signs for the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_mag_s3 <= nx[SW-1] ? SW'(-nx) : SW'(nx);
			ny_mag_s3 <= ny[SW-1] ? SW'(-ny) : SW'(ny);
			w_mag_s3  <= w[SW-1]  ? SW'(-w)  : SW'(w);
			negx_s3   <= nx[SW-1] ^ w[SW-1];
			negy_s3   <= ny[SW-1] ^ w[SW-1];
			wzero_s3  <= (w == '0);
			wpos_s3   <= ~w[SW-1] & (w != '0);
		end
	end

	hpp_div #(.DW(DW), .NW(NW), .DWID(SW)) u_divx (
		.clk(clk), .en(adv),
		.num({nx_mag_s3, {FB{1'b0}}}), .den(w_mag_s3),
		.quot(qx), .ovf(ovfx)
	);

	hpp_div #(.DW(DW), .NW(NW), .DWID(SW)) u_divy (
		.clk(clk), .en(adv),
		.num({ny_mag_s3, {FB{1'b0}}}), .den(w_mag_s3),
		.quot(qy), .ovf(ovfy)
	);

	// Carry valid bits and flags alongside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_d[i] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s3;
			for (int i = 1; i < LAT; i++) v_d[i] <= v_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			negx_d[0]  <= negx_s3;
			negy_d[0]  <= negy_s3;
			wzero_d[0] <= wzero_s3;
			wpos_d[0]  <= wpos_s3;
			for (int i = 1; i < LAT; i++) begin
				negx_d[i]  <= negx_d[i-1];
				negy_d[i]  <= negy_d[i-1];
				wzero_d[i] <= wzero_d[i-1];
				wpos_d[i]  <= wpos_d[i-1];
			end
		end
	end

	// Clamp the quotient magnitude and apply the sign
	function automatic logic [DW-1:0] sat_sign(input logic [QB-1:0] q, input logic ovf,
		input logic neg);
		logic [QB-1:0] cap;
		logic [QB-1:0] mag;
		logic [QB-1:0] val;
		begin
			cap = neg ? (QB'(1) << (DW-1)) : ((QB'(1) << (DW-1)) - QB'(1));
			mag = (ovf || q > cap) ? cap : q;
			val = neg ? -mag : mag;
			sat_sign = val[DW-1:0];
		end
	endfunction

	assign resx = sat_sign(qx, ovfx, negx_d[LAT-1]);
	assign resy = sat_sign(qy, ovfy, negy_d[LAT-1]);

	// Output register; hold while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_d[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q  <= wzero_d[LAT-1] ? 32'sd0 : 32'(signed'(resx));
			sy_q  <= wzero_d[LAT-1] ? 32'sd0 : 32'(signed'(resy));
			vis_q <= wpos_d[LAT-1];
		end
	end

endmodule

// ===== design/hpp_regs.sv =====
// APB-style register file holding the projection matrix coefficients.
// Depends on hpp_pkg.
module hpp_regs import hpp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  reg_word_t            pwdata,
	output reg_word_t            prdata,
	output logic                 pready,
	output hpp_matrix_t          matrix
);

	logic [2:0]  idx;
	logic        wr_en;
	hpp_matrix_t mat_q;

	assign idx    = paddr[ADDR_BITS-1:3];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign matrix = mat_q;

	// Write the addressed word; drop writes beyond the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q.r0c01 <= RST_ROW0_COLS01;
			mat_q.r0c23 <= RST_ZERO;
			mat_q.r1c01 <= RST_ROW1_COLS01;
			mat_q.r1c23 <= RST_ZERO;
			mat_q.r3c01 <= RST_ZERO;
			mat_q.r3c23 <= RST_ROW3_COLS23;
		end else if (wr_en) begin
			case (idx)
				REG_ROW0_COLS01: mat_q.r0c01 <= pwdata;
				REG_ROW0_COLS23: mat_q.r0c23 <= pwdata;
				REG_ROW1_COLS01: mat_q.r1c01 <= pwdata;
				REG_ROW1_COLS23: mat_q.r1c23 <= pwdata;
				REG_ROW3_COLS01: mat_q.r3c01 <= pwdata;
				REG_ROW3_COLS23: mat_q.r3c23 <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back the addressed word
	always_comb begin
		case (idx)
			REG_ROW0_COLS01: prdata = mat_q.r0c01;
			REG_ROW0_COLS23: prdata = mat_q.r0c23;
			REG_ROW1_COLS01: prdata = mat_q.r1c01;
			REG_ROW1_COLS23: prdata = mat_q.r1c23;
			REG_ROW3_COLS01: prdata = mat_q.r3c01;
			REG_ROW3_COLS23: prdata = mat_q.r3c23;
			default:         prdata = RST_ZERO;
		endcase
	end

endmodule

// ===== design/hpp_dot.sv =====
// Two-stage row dot product: products floored to the fraction width, then summed.
// Depends on hpp_pkg.
module hpp_dot import hpp_pkg::*; #(
	parameter int DW = 32,
	parameter int FB = 16,
	parameter int SW = 2*DW-FB+2
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] c0,
	input  logic signed [DW-1:0] c1,
	input  logic signed [DW-1:0] c2,
	input  logic signed [DW-1:0] c3,
	input  logic signed [DW-1:0] px,
	input  logic signed [DW-1:0] py,
	input  logic signed [DW-1:0] pz,
	output logic signed [SW-1:0] sum
);

	localparam int PW = 2*DW-FB;

	logic signed [2*DW-1:0] prod0, prod1, prod2;
	logic signed [PW-1:0]   p0_s1, p1_s1, p2_s1;
	logic signed [DW-1:0]   c3_s1;
	logic signed [SW-1:0]   sum_s2;

	assign prod0 = c0 * px;
	assign prod1 = c1 * py;
	assign prod2 = c2 * pz;

	// Register the floored products
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PW'(prod0 >>> FB);
			p1_s1 <= PW'(prod1 >>> FB);
			p2_s1 <= PW'(prod2 >>> FB);
			c3_s1 <= c3;
		end
	end

	// Add the products and the translation column
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SW'(p0_s1) + SW'(p1_s1) + SW'(p2_s1) + SW'(c3_s1);
		end
	end

	assign sum = sum_s2;

endmodule

// ===== design/hpp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Depends on hpp_pkg.
module hpp_div import hpp_pkg::*; #(
	parameter int DW   = 32,
	parameter int NW   = 66,
	parameter int DWID = 50
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NW-1:0]   num,
	input  logic [DWID-1:0] den,
	output logic [DW:0]     quot,
	output logic            ovf
);

	localparam int QB = DW+1;
	localparam int RW = DWID+QB;

	logic [RW-1:0]   rem_s [0:QB];
	logic [DWID-1:0] den_s [0:QB];
	logic [QB-1:0]   q_s   [0:QB];
	logic            ovf_s [0:QB];

	// Entry stage: flag quotients too large for the result bits
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= RW'(num >> QB) >= RW'(den);
			rem_s[0] <= RW'(num);
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 1; k <= QB; k++) begin : g_step
		localparam int SH = QB-k;
		logic [RW-1:0] shd;
		logic [RW:0]   diff;
		logic          take;

		assign shd  = RW'(den_s[k-1]) << SH;
		assign diff = {1'b0, rem_s[k-1]} - {1'b0, shd};
		assign take = ~diff[RW];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[RW-1:0] : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				q_s[k]   <= {q_s[k-1][QB-2:0], take};
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quot = q_s[QB];
	assign ovf  = ovf_s[QB];

endmodule

// ===== design/hpp_checker.sv =====
// Port-level checker for the homogeneous point projector, bound to the top level.
// Depends on hpp_pkg and homogeneous_point_projector.
module hpp_checker import hpp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               point_ready,
	input logic               screen_valid,
	input logic               screen_ready,
	input logic signed [31:0] screen_x,
	input logic signed [31:0] screen_y,
	input logic               visible
);

	// Hold a stalled result
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && !screen_ready |=> screen_valid)
		else $error("result transaction dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && !screen_ready |=>
		$stable(screen_x) && $stable(screen_y) && $stable(visible))
		else $error("result payload changed while stalled");

	// Accept points whenever the output is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!screen_valid |-> point_ready)
		else $error("input refused with an empty output stage");

	// Freeze intake while a result waits
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && !screen_ready |-> !point_ready)
		else $error("input taken while the pipeline is stalled");

endmodule

bind homogeneous_point_projector hpp_checker u_hpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.point_ready (point_ready),
	.screen_valid(screen_valid),
	.screen_ready(screen_ready),
	.screen_x    (screen_x),
	.screen_y    (screen_y),
	.visible     (visible)
);

// ===== tb/testbench.sv =====
// Self-checking bench for the homogeneous point projector top level.
// Depends on hpp_pkg and the design files; computes expected screen results itself.
module testbench;
	import hpp_pkg::*;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} point_t;

	typedef struct {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic               vis;
	} screen_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 point_valid = 1'b0;
	logic                 point_ready;
	logic signed [31:0]   point_x = '0;
	logic signed [31:0]   point_y = '0;
	logic signed [31:0]   point_z = '0;
	logic                 screen_valid;
	logic                 screen_ready = 1'b0;
	logic signed [31:0]   screen_x;
	logic signed [31:0]   screen_y;
	logic                 visible;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	reg_word_t            pwdata = '0;
	reg_word_t            prdata;
	logic                 pready;

	reg_word_t matrix [NUM_REGS];
	point_t    pending_points [$];
	screen_t   expected_screens [$];
	int        mismatches = 0;
	int        screens_seen = 0;
	int        hold_off = 0;
	bit        feeding = 1'b0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        stall_phase = 0;

	homogeneous_point_projector DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Signed coefficient of row r (0, 1, 3) column c
	function automatic longint coef_at(int r, int c);
		reg_word_t w;
		w = matrix[(r == 3 ? 4 : r * 2) + c / 2];
		return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
	endfunction

	function automatic longint row_total(int r, point_t p);
		longint acc;
		longint pv [3];
		pv[0] = p.px; pv[1] = p.py; pv[2] = p.pz;
		acc = coef_at(r, 3);
		for (int c = 0; c < 3; c++)
			acc += (coef_at(r, c) * pv[c]) >>> 16;
		return acc;
	endfunction

	// Truncating divide in Q16.16, saturated to 32 bits
	function automatic logic signed [31:0] ratio_sat(longint n, longint d);
		bit neg;
		logic [63:0] un, ud, qi, rem, frac, cap, mag;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		qi = un / ud;
		rem = un % ud;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= ud) begin
				rem -= ud;
				frac |= 1;
			end
		end
		cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (qi > 64'h8000) mag = cap;
		else mag = (qi << 16) | frac;
		if (mag > cap) mag = cap;
		return neg ? -mag[31:0] : mag[31:0];
	endfunction

	function automatic screen_t project_point(point_t p);
		screen_t s;
		longint nx, ny, w;
		nx = row_total(0, p);
		ny = row_total(1, p);
		w = row_total(3, p);
		if (w == 0) begin
			s.sx = 0; s.sy = 0; s.vis = 0;
		end else begin
			s.sx = ratio_sat(nx, w);
			s.sy = ratio_sat(ny, w);
			s.vis = (w > 0);
		end
		return s;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatches++;
	endtask

	// Driver: bursts of transactions separated by random gaps
	always @(posedge clk) begin
		if (point_valid && point_ready) begin
			expected_screens.push_back(project_point('{point_x, point_y, point_z}));
		end
		if (!point_valid || point_ready) begin
			if (feeding && pending_points.size() > 0 && gap_left == 0) begin
				point_t p;
				p = pending_points.pop_front();
				point_valid <= 1'b1;
				point_x <= p.px; point_y <= p.py; point_z <= p.pz;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
				end else burst_left--;
			end else begin
				point_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
	end

	// Monitor: stall on a pattern and on long hold-offs, check each transaction
	always @(posedge clk) begin
		if (screen_valid && screen_ready) begin
			screen_t e;
			screens_seen++;
			if (expected_screens.size() == 0) begin
				report_mismatch("unexpected result", screen_x, 0);
			end else begin
				e = expected_screens.pop_front();
				if (screen_x !== e.sx) report_mismatch("screen_x", screen_x, e.sx);
				if (screen_y !== e.sy) report_mismatch("screen_y", screen_y, e.sy);
				if (visible !== e.vis) report_mismatch("visible", visible, e.vis);
			end
		end
		stall_phase = (stall_phase + 1) % 23;
		if (hold_off > 0) begin
			hold_off--;
			screen_ready <= 1'b0;
		end else if (stall_phase < 8) begin
			screen_ready <= 1'b1;
		end else begin
			screen_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic reg_write(logic [2:0] idx, reg_word_t val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_BITS'(idx) << 3; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		matrix[idx] = val;
	endtask

	task automatic drain_all();
		feeding = 1'b1;
		while (pending_points.size() > 0 || point_valid || expected_screens.size() > 0)
			@(posedge clk);
		feeding = 1'b0;
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] small_coef();
		return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
	endfunction

	task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		pending_points.push_back('{x, y, z});
	endtask

	initial begin
		matrix[0] = RST_ROW0_COLS01; matrix[1] = RST_ZERO;
		matrix[2] = RST_ROW1_COLS01; matrix[3] = RST_ZERO;
		matrix[4] = RST_ZERO;        matrix[5] = RST_ROW3_COLS23;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults give w = 1, so x and y pass straight through
		queue_point(0, 0, 0);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_point(32'h1_0000, 32'h2_0000, 32'h0);
		drain_all();
		// Perspective row: w = z, divisor zero, negative, tiny
		reg_write(REG_ROW3_COLS23, 64'h0000_0000_0001_0000);
		reg_write(REG_ROW3_COLS01, 64'h0);
		queue_point(32'h1_0000, 32'h1_0000, 32'h0);
		queue_point(32'h1_0000, 32'hFFFF_0000, 32'hFFFF_0000);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_point(32'h3_0000, 32'h5_0000, 32'h2_0000);
		queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		drain_all();

		// Random phases over several matrices, extremes among them
		for (int ph = 0; ph < 10; ph++) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				if (ph == 0) reg_write(3'(r), 64'hFFFF_FFFF_FFFF_FFFF);
				else if (ph == 1) reg_write(3'(r), 64'h8000_0000_7FFF_FFFF);
				else if (ph == 9) reg_write(3'(r), '0);
				else if (ph % 2 == 0) reg_write(3'(r), {rand_word(), rand_word()});
				else reg_write(3'(r), {small_coef(), small_coef()});
			end
			for (int i = 0; i < 190; i++) begin
				if ($urandom_range(0, 1))
					queue_point(rand_word(), rand_word(), rand_word());
				else
					queue_point($urandom, $urandom, $urandom);
			end
			feeding = 1'b1;
			if (ph == 3) begin
				repeat (20) @(posedge clk);
				hold_off = 200;
			end
			drain_all();
		end

		$display("covered %0d projected points over 12 matrix settings", screens_seen);
		$display("including zero, negative and saturating divisors");
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
